// ----- hw/rtl/mbt_pkg.sv -----
`default_nettype none

package mbt_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int SLOT_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // request kinds
  localparam logic [2:0] RQ_FC2  = 3'd0;
  localparam logic [2:0] RQ_FC3  = 3'd1;
  localparam logic [2:0] RQ_FC4  = 3'd2;
  localparam logic [2:0] RQ_FC5  = 3'd3;
  localparam logic [2:0] RQ_FC6  = 3'd4;
  localparam logic [2:0] RQ_FC15 = 3'd5;
  localparam logic [2:0] RQ_FC16 = 3'd6;
  localparam logic [2:0] RQ_BAD  = 3'd7;

  // Modbus function codes
  localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT    = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
  localparam logic [7:0] FC_WRITE_REG     = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS    = 8'h10;
  localparam logic [7:0] FC_NONE          = 8'h00;

  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;

  // MBAP header and PDU byte positions
  localparam logic [15:0] POS_TID_HI = 16'd0;
  localparam logic [15:0] POS_TID_LO = 16'd1;
  localparam logic [15:0] POS_LEN_HI = 16'd4;
  localparam logic [15:0] POS_LEN_LO = 16'd5;
  localparam logic [15:0] POS_UNIT   = 16'd6;
  localparam logic [15:0] POS_FUNC   = 16'd7;
  localparam logic [15:0] POS_PDU1   = 16'd8;
  localparam logic [15:0] POS_PDU2   = 16'd9;
  localparam logic [15:0] POS_PDU3   = 16'd10;
  localparam logic [15:0] POS_PDU4   = 16'd11;

  typedef enum logic [2:0] {
    RK_ACCEPTED  = 3'd0,
    RK_WORD      = 3'd1,
    RK_BITS      = 3'd2,
    RK_COMPLETE  = 3'd3,
    RK_UNKNOWN   = 3'd4,
    RK_MISMATCH  = 3'd5,
    RK_FULL      = 3'd6,
    RK_MALFORMED = 3'd7
  } result_kind_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx_byte;
    logic [2:0]  req_kind;
    logic [15:0] req_address;
    logic [15:0] req_operand;
  } item_t;

  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  transaction_id;
    logic [15:0]  address;
    logic [15:0]  value;
    logic [3:0]   bit_count;
    logic         success;
    logic         last;
  } result_t;

  typedef struct packed {
    logic step;
    logic load;
  } mbt_cmd_t;

  typedef struct packed {
    logic has_result;
  } mbt_status_t;

  function automatic logic [7:0] code_of_kind(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      RQ_FC2:  c = FC_READ_DISCRETE;
      RQ_FC3:  c = FC_READ_HOLDING;
      RQ_FC4:  c = FC_READ_INPUT;
      RQ_FC5:  c = FC_WRITE_COIL;
      RQ_FC6:  c = FC_WRITE_REG;
      RQ_FC15: c = FC_WRITE_COILS;
      RQ_FC16: c = FC_WRITE_REGS;
      default: c = FC_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mbt_ctrl.sv -----
`default_nettype none

module mbt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  output logic                     result_valid,
  input  wire logic                result_stall,
  input  wire mbt_pkg::mbt_status_t stat,
  output mbt_pkg::mbt_cmd_t        cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_t;

  state_t state;

  // one item at a time; a result parks the input side until it is taken
  always_comb begin
    cmd.step = item_valid && !item_stall;
    cmd.load = cmd.step && stat.has_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      item_stall   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state        <= ST_HOLD;
            item_stall   <= 1'b1;
            result_valid <= 1'b1;
          end
        end
        ST_HOLD: begin
          if (!result_stall) begin
            state        <= ST_IDLE;
            item_stall   <= 1'b0;
            result_valid <= 1'b0;
          end
        end
        default: begin
          state        <= ST_IDLE;
          item_stall   <= 1'b0;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input taken while a result is pending");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> result_valid)
    else $error("result not presented after load");

  a_taken_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=> !result_valid)
    else $error("result repeated after hand-off");

endmodule

`default_nettype wire

// ----- hw/rtl/mbt_datapath.sv -----
`default_nettype none

module mbt_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mbt_pkg::item_t    item,
  input  wire mbt_pkg::mbt_cmd_t cmd,
  output mbt_pkg::mbt_status_t   stat,
  output mbt_pkg::result_t       result
);

  localparam int DEPTH = mbt_pkg::PENDING_DEPTH;
  localparam int SW    = mbt_pkg::SLOT_W;

  // pending table
  logic        slot_valid   [DEPTH];
  logic [15:0] slot_tid     [DEPTH];
  logic [2:0]  slot_kind    [DEPTH];
  logic [15:0] slot_address [DEPTH];
  logic [15:0] slot_operand [DEPTH];

  // frame parser state
  logic [15:0] next_tid, next_tid_next;
  logic [15:0] byte_pos, byte_pos_next;
  logic [15:0] frame_len, frame_len_next;
  logic [15:0] frame_tid, frame_tid_next;
  logic [SW-1:0] match_slot, match_slot_next;
  logic        match_ok, match_ok_next;
  logic [7:0]  data_bytes, data_bytes_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [15:0] items_done, items_done_next;
  logic [15:0] field_one, field_one_next;
  logic [15:0] field_two, field_two_next;

  logic          alloc_en, release_en;
  logic          free_found, hit_found;
  logic [SW-1:0] free_idx, hit_idx;
  logic [2:0]    sel_kind;
  logic [15:0]   sel_addr, sel_op;
  mbt_pkg::result_t res;
  logic          has_res;

  // lowest free slot and lowest slot holding the frame's id
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit_found  = 1'b0;
    hit_idx    = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
      if (slot_valid[i] && slot_tid[i] == frame_tid) begin
        hit_found = 1'b1;
        hit_idx   = SW'(i);
      end
    end
  end

  assign sel_kind = slot_kind[match_slot];
  assign sel_addr = slot_address[match_slot];
  assign sel_op   = slot_operand[match_slot];

  // next state and result of one item
  always_comb begin
    logic [7:0]  b;
    logic [15:0] pos, len, d, left, f2;
    logic [3:0]  cnt;
    logic [7:0]  mask;
    logic        fin;
    b = item.rx_byte;
    pos = byte_pos;
    len = '0;
    d = pos - 16'd9;
    left = '0;
    f2 = '0;
    cnt = '0;
    mask = '0;
    fin = 1'b0;
    next_tid_next   = next_tid;
    byte_pos_next   = byte_pos;
    frame_len_next  = frame_len;
    frame_tid_next  = frame_tid;
    match_slot_next = match_slot;
    match_ok_next   = match_ok;
    data_bytes_next = data_bytes;
    held_byte_next  = held_byte;
    items_done_next = items_done;
    field_one_next  = field_one;
    field_two_next  = field_two;
    alloc_en   = 1'b0;
    release_en = 1'b0;
    has_res    = 1'b0;
    res        = '0;
    res.last   = 1'b1;

    if (item.func) begin
      // new request
      has_res = 1'b1;
      res.transaction_id = next_tid;
      if (item.req_kind == mbt_pkg::RQ_BAD) begin
        res.kind = mbt_pkg::RK_MALFORMED;
      end else if (!free_found) begin
        res.kind = mbt_pkg::RK_FULL;
      end else begin
        alloc_en      = 1'b1;
        next_tid_next = next_tid + 16'd1;
        res.kind      = mbt_pkg::RK_ACCEPTED;
        res.address   = item.req_address;
        res.value     = item.req_operand;
      end
    end else begin
      res.transaction_id = frame_tid;
      if (pos < mbt_pkg::POS_UNIT) begin
        // MBAP header
        if (pos == mbt_pkg::POS_TID_HI) begin
          frame_tid_next = {b, 8'h00};
          match_ok_next  = 1'b0;
        end else if (pos == mbt_pkg::POS_TID_LO) begin
          frame_tid_next = {frame_tid[15:8], b};
        end else if (pos == mbt_pkg::POS_LEN_HI) begin
          frame_len_next = {b, 8'h00};
        end else if (pos == mbt_pkg::POS_LEN_LO) begin
          len = {frame_len[15:8], b};
          frame_len_next = len;
          if (len < 16'd2) begin
            has_res  = 1'b1;
            res.kind = mbt_pkg::RK_MALFORMED;
          end
          fin = (len == 16'd0);
        end
      end else begin
        frame_len_next = frame_len - 16'd1;
        fin = (frame_len == 16'd1);
        if (pos == mbt_pkg::POS_UNIT) begin
          // id lookup
          if (frame_len >= 16'd2) begin
            match_ok_next = hit_found;
            if (hit_found) begin
              match_slot_next = hit_idx;
            end else begin
              has_res  = 1'b1;
              res.kind = mbt_pkg::RK_UNKNOWN;
            end
          end
        end else if (match_ok) begin
          if (pos == mbt_pkg::POS_FUNC) begin
            if (b != mbt_pkg::code_of_kind(sel_kind)) begin
              has_res       = 1'b1;
              res.kind      = mbt_pkg::RK_MISMATCH;
              res.value     = {8'h00, b};
              release_en    = 1'b1;
              match_ok_next = 1'b0;
            end
          end else if (sel_kind <= mbt_pkg::RQ_FC4) begin
            // read responses
            if (pos == mbt_pkg::POS_PDU1) begin
              data_bytes_next = b;
              items_done_next = '0;
            end else if (d < {8'h00, data_bytes}) begin
              if (sel_kind == mbt_pkg::RQ_FC2) begin
                left = (items_done < sel_op) ? (sel_op - items_done) : 16'd0;
                cnt  = (left < 16'd8) ? left[3:0] : 4'd8;
                mask = 8'hFF >> (4'd8 - cnt);
                if (cnt != 4'd0) begin
                  has_res         = 1'b1;
                  res.kind        = mbt_pkg::RK_BITS;
                  res.address     = sel_addr + items_done;
                  res.value       = {8'h00, b & mask};
                  res.bit_count   = cnt;
                  items_done_next = items_done + {12'h000, cnt};
                end
              end else if (!d[0]) begin
                held_byte_next = b;
              end else begin
                has_res         = 1'b1;
                res.kind        = mbt_pkg::RK_WORD;
                res.address     = sel_addr + items_done;
                res.value       = {held_byte, b};
                items_done_next = items_done + 16'd1;
              end
            end
          end else begin
            // write echo
            if (pos == mbt_pkg::POS_PDU1) begin
              field_one_next = {b, 8'h00};
            end else if (pos == mbt_pkg::POS_PDU2) begin
              field_one_next = {field_one[15:8], b};
            end else if (pos == mbt_pkg::POS_PDU3) begin
              field_two_next = {b, 8'h00};
            end else if (pos == mbt_pkg::POS_PDU4) begin
              f2 = {field_two[15:8], b};
              field_two_next = f2;
              has_res     = 1'b1;
              res.kind    = mbt_pkg::RK_COMPLETE;
              res.address = field_one;
              if (sel_kind == mbt_pkg::RQ_FC5) begin
                res.success = (sel_addr == field_one) &&
                              (sel_op[0] ? (f2 == mbt_pkg::COIL_ON)
                                         : (f2 == mbt_pkg::COIL_OFF));
                res.value   = {15'h0000, f2 == mbt_pkg::COIL_ON};
              end else begin
                res.success = (sel_addr == field_one) && (sel_op == f2);
                res.value   = f2;
              end
            end
          end
        end
        // frame end frees the slot; a short write echo is malformed
        if (fin && match_ok_next) begin
          if (sel_kind > mbt_pkg::RQ_FC4 && pos < mbt_pkg::POS_PDU4) begin
            has_res  = 1'b1;
            res      = '0;
            res.last = 1'b1;
            res.kind = mbt_pkg::RK_MALFORMED;
            res.transaction_id = frame_tid;
          end
          release_en    = 1'b1;
          match_ok_next = 1'b0;
        end
      end
      if (fin) begin
        byte_pos_next = '0;
      end else if (byte_pos != 16'hFFFF) begin
        byte_pos_next = byte_pos + 16'd1;
      end
    end
  end

  assign stat.has_result = has_res;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_tid   <= 16'd1;
      byte_pos   <= '0;
      frame_len  <= '0;
      frame_tid  <= '0;
      match_slot <= '0;
      match_ok   <= 1'b0;
      data_bytes <= '0;
      held_byte  <= '0;
      items_done <= '0;
      field_one  <= '0;
      field_two  <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else if (cmd.step) begin
      next_tid   <= next_tid_next;
      byte_pos   <= byte_pos_next;
      frame_len  <= frame_len_next;
      frame_tid  <= frame_tid_next;
      match_slot <= match_slot_next;
      match_ok   <= match_ok_next;
      data_bytes <= data_bytes_next;
      held_byte  <= held_byte_next;
      items_done <= items_done_next;
      field_one  <= field_one_next;
      field_two  <= field_two_next;
      if (alloc_en) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (release_en) begin
        slot_valid[match_slot] <= 1'b0;
      end
    end
  end

  // slot payload, written on allocation
  always_ff @(posedge clk) begin
    if (cmd.step && alloc_en) begin
      slot_tid[free_idx]     <= next_tid;
      slot_kind[free_idx]    <= item.req_kind;
      slot_address[free_idx] <= item.req_address;
      slot_operand[free_idx] <= item.req_operand;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result <= res;
    end
  end

  a_tid_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.step && alloc_en |=> next_tid == $past(next_tid) + 16'd1)
    else $error("transaction id did not advance on allocation");

  a_slot_freed: assert property (@(posedge clk) disable iff (rst)
    cmd.step && release_en |=> !slot_valid[$past(match_slot)])
    else $error("matched slot still pending after release");

  a_one_table_op: assert property (@(posedge clk) disable iff (rst)
    !(alloc_en && release_en))
    else $error("allocation and release in one item");

endmodule

`default_nettype wire

// ----- hw/rtl/modbus_tcp_response_tracker.sv -----
// channel   signals                              item
// ------    -----------------------------------  ---------------------------------
// input     item_valid, item_stall, item         request or one received byte
// output    result_valid, result_stall, result   accepted/word/bits/complete/error
//
// An item that gives no result leaves the input free for the next item; one that
// gives a result is taken and the input then stalls until the result is handed
// off.
// The pending-slot search and id match are combinational parallel compares.
// rst (synchronous) frees all slots and restarts framing; next id is 1.
`default_nettype none

module modbus_tcp_response_tracker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire mbt_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output mbt_pkg::result_t      result
);

  mbt_pkg::mbt_cmd_t    cmd;
  mbt_pkg::mbt_status_t stat;

  mbt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  mbt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

`default_nettype wire

// ----- verif/modbus_tcp_response_tracker_test.sv -----
`default_nettype none

module modbus_tcp_response_tracker_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DEPTH = mbt_pkg::PENDING_DEPTH;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  mbt_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  mbt_pkg::result_t result;

  modbus_tcp_response_tracker DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // tracker predictor and queue of expected results
  class tracker_scoreboard;
    logic [15:0] next_tid;
    logic        slot_used[DEPTH];
    logic [15:0] slot_tid[DEPTH];
    logic [2:0]  slot_kind[DEPTH];
    logic [15:0] slot_addr[DEPTH];
    logic [15:0] slot_op[DEPTH];
    logic [15:0] pos;
    logic [15:0] frame_left;
    logic [15:0] frame_tid;
    int          hit_slot;
    logic        hit;
    logic [7:0]  byte_count;
    logic [7:0]  held;
    logic [15:0] done_cnt;
    logic [15:0] echo_addr;
    logic [15:0] echo_val;
    mbt_pkg::result_t pending[$];
    int          errors;

    function new();
      next_tid = 16'd1;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      pos = 0; frame_left = 0; frame_tid = 0; hit_slot = 0; hit = 0;
      byte_count = 0; held = 0; done_cnt = 0; echo_addr = 0; echo_val = 0;
      errors = 0;
    endfunction

    function automatic logic [7:0] fcode(logic [2:0] k);
      case (k)
        mbt_pkg::RQ_FC2:  return mbt_pkg::FC_READ_DISCRETE;
        mbt_pkg::RQ_FC3:  return mbt_pkg::FC_READ_HOLDING;
        mbt_pkg::RQ_FC4:  return mbt_pkg::FC_READ_INPUT;
        mbt_pkg::RQ_FC5:  return mbt_pkg::FC_WRITE_COIL;
        mbt_pkg::RQ_FC6:  return mbt_pkg::FC_WRITE_REG;
        mbt_pkg::RQ_FC15: return mbt_pkg::FC_WRITE_COILS;
        mbt_pkg::RQ_FC16: return mbt_pkg::FC_WRITE_REGS;
        default: return mbt_pkg::FC_NONE;
      endcase
    endfunction

    function void push(mbt_pkg::result_kind_t k, logic [15:0] t, logic [15:0] a,
                       logic [15:0] v, logic [3:0] bc, logic ok);
      mbt_pkg::result_t r;
      r.kind = k; r.transaction_id = t; r.address = a; r.value = v;
      r.bit_count = bc; r.success = ok; r.last = 1'b1;
      pending.insert(pending.size(), r);
    endfunction

    function void take_request(logic [2:0] k, logic [15:0] a, logic [15:0] op);
      int free;
      free = -1;
      if (k == mbt_pkg::RQ_BAD) begin
        push(mbt_pkg::RK_MALFORMED, next_tid, 0, 0, 0, 0);
        return;
      end
      for (int i = DEPTH - 1; i >= 0; i--) if (!slot_used[i]) free = i;
      if (free < 0) begin
        push(mbt_pkg::RK_FULL, next_tid, 0, 0, 0, 0);
        return;
      end
      slot_used[free] = 1; slot_tid[free] = next_tid; slot_kind[free] = k;
      slot_addr[free] = a; slot_op[free] = op;
      push(mbt_pkg::RK_ACCEPTED, next_tid, a, op, 0, 0);
      next_tid++;
    endfunction

    function void take_byte(logic [7:0] b);
      logic        fin;
      logic [15:0] rem;
      logic [2:0]  k;
      logic        ok;
      int          d;
      int          cnt;
      logic [15:0] lft;
      fin = 0;
      if (pos < 6) begin
        case (pos)
          mbt_pkg::POS_TID_HI: begin frame_tid = {b, 8'h00}; hit = 0; end
          mbt_pkg::POS_TID_LO: frame_tid[7:0] = b;
          mbt_pkg::POS_LEN_HI: frame_left = {b, 8'h00};
          mbt_pkg::POS_LEN_LO: begin
            frame_left[7:0] = b;
            if (frame_left < 2) push(mbt_pkg::RK_MALFORMED, frame_tid, 0, 0, 0, 0);
            if (frame_left == 0) fin = 1;
          end
          default: ;
        endcase
      end else begin
        rem = frame_left;
        frame_left = rem - 16'd1;
        if (frame_left == 0) fin = 1;
        if (pos == mbt_pkg::POS_UNIT) begin
          if (rem >= 2) begin
            hit = 0;
            for (int i = 0; i < DEPTH; i++)
              if (!hit && slot_used[i] && slot_tid[i] == frame_tid) begin
                hit = 1; hit_slot = i;
              end
            if (!hit) push(mbt_pkg::RK_UNKNOWN, frame_tid, 0, 0, 0, 0);
          end
        end else if (hit) begin
          k = slot_kind[hit_slot];
          if (pos == mbt_pkg::POS_FUNC) begin
            if (b != fcode(k)) begin
              push(mbt_pkg::RK_MISMATCH, frame_tid, 0, {8'h00, b}, 0, 0);
              slot_used[hit_slot] = 0; hit = 0;
            end
          end else if (k <= mbt_pkg::RQ_FC4) begin
            if (pos == mbt_pkg::POS_PDU1) begin
              byte_count = b; done_cnt = 0;
            end else begin
              d = pos - 9;
              if (d < byte_count) begin
                if (k == mbt_pkg::RQ_FC2) begin
                  lft = (done_cnt < slot_op[hit_slot]) ? slot_op[hit_slot] - done_cnt : 16'd0;
                  cnt = (lft < 8) ? lft : 8;
                  if (cnt > 0) begin
                    push(mbt_pkg::RK_BITS, frame_tid, slot_addr[hit_slot] + done_cnt,
                         {8'h00, b & ((8'd1 << cnt) - 8'd1)}, 4'(cnt), 0);
                    done_cnt = done_cnt + 16'(cnt);
                  end
                end else if (d % 2 == 0) begin
                  held = b;
                end else begin
                  push(mbt_pkg::RK_WORD, frame_tid, slot_addr[hit_slot] + done_cnt,
                       {held, b}, 0, 0);
                  done_cnt++;
                end
              end
            end
          end else begin
            case (pos)
              mbt_pkg::POS_PDU1: echo_addr = {b, 8'h00};
              mbt_pkg::POS_PDU2: echo_addr[7:0] = b;
              mbt_pkg::POS_PDU3: echo_val = {b, 8'h00};
              mbt_pkg::POS_PDU4: begin
                echo_val[7:0] = b;
                if (k == mbt_pkg::RQ_FC5) begin
                  ok = (slot_addr[hit_slot] == echo_addr) &&
                       (slot_op[hit_slot][0] ? echo_val == mbt_pkg::COIL_ON
                                             : echo_val == mbt_pkg::COIL_OFF);
                  push(mbt_pkg::RK_COMPLETE, frame_tid, echo_addr,
                       {15'd0, echo_val == mbt_pkg::COIL_ON}, 0, ok);
                end else begin
                  ok = (slot_addr[hit_slot] == echo_addr) && (slot_op[hit_slot] == echo_val);
                  push(mbt_pkg::RK_COMPLETE, frame_tid, echo_addr, echo_val, 0, ok);
                end
              end
              default: ;
            endcase
          end
        end
        if (fin && hit) begin
          if (slot_kind[hit_slot] > mbt_pkg::RQ_FC4 && pos < mbt_pkg::POS_PDU4)
            push(mbt_pkg::RK_MALFORMED, frame_tid, 0, 0, 0, 0);
          slot_used[hit_slot] = 0; hit = 0;
        end
      end
      if (fin) pos = 0;
      else if (pos != 16'hFFFF) pos++;
    endfunction

    function void note_item(mbt_pkg::item_t it);
      if (it.func) take_request(it.req_kind, it.req_address, it.req_operand);
      else take_byte(it.rx_byte);
    endfunction

    function void check_result(mbt_pkg::result_t got);
      mbt_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with none expected: kind %0d tid %0h", got.kind, got.transaction_id);
        errors++;
        return;
      end
      exp_r = pending[0];
      pending.delete(0);
      if (got.kind != exp_r.kind) begin
        $error("kind: expected %0d got %0d", exp_r.kind, got.kind); errors++;
      end
      if (got.transaction_id != exp_r.transaction_id) begin
        $error("transaction_id: expected %0h got %0h", exp_r.transaction_id,
               got.transaction_id); errors++;
      end
      if (got.address != exp_r.address) begin
        $error("address: expected %0h got %0h", exp_r.address, got.address); errors++;
      end
      if (got.value != exp_r.value) begin
        $error("value: expected %0h got %0h", exp_r.value, got.value); errors++;
      end
      if (got.bit_count != exp_r.bit_count) begin
        $error("bit_count: expected %0d got %0d", exp_r.bit_count, got.bit_count); errors++;
      end
      if (got.success != exp_r.success) begin
        $error("success: expected %0d got %0d", exp_r.success, got.success); errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d got %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  tracker_scoreboard sb;
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_off;
  int  items_sent;
  int  cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: check accepted results, stall at random or hold off
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(result);
    end
    result_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // offer one item, hold until taken, with random idle cycles first
  task automatic send(mbt_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_req(logic [2:0] k, logic [15:0] a, logic [15:0] op);
    mbt_pkg::item_t it;
    it = '0;
    it.func = 1; it.req_kind = k; it.req_address = a; it.req_operand = op;
    it.rx_byte = 8'($urandom);
    send(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    mbt_pkg::item_t it;
    it = '0;
    it.req_kind = 3'($urandom);
    it.req_address = 16'($urandom);
    it.req_operand = 16'($urandom);
    it.func = 0; it.rx_byte = b;
    send(it);
  endtask

  // frame body byte; a length field that opens here stays short
  task automatic send_body(logic [7:0] b);
    if (sb.pos == mbt_pkg::POS_LEN_HI) send_byte(8'h00);
    else if (sb.pos == mbt_pkg::POS_LEN_LO) send_byte(b & 8'h0F);
    else send_byte(b);
  endtask

  // complete any short frame left open
  task automatic finish_frame();
    while (sb.pos != 0) send_body(8'($urandom));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_header(logic [15:0] t, logic [15:0] len);
    send_byte(t[15:8]); send_byte(t[7:0]);
    send_byte(8'($urandom)); send_byte(8'($urandom));
    send_byte(len[15:8]); send_byte(len[7:0]);
  endtask

  // one response frame for a given tid; kind picks a plausible body
  task automatic send_frame(logic [15:0] t, logic [2:0] k, logic [15:0] a, logic [15:0] op,
                            bit noisy);
    int nb;
    logic [7:0] code;
    code = sb.fcode(k);
    if (noisy && $urandom_range(3) == 0)
      code = $urandom_range(1) ? (code | 8'h80) : 8'($urandom);
    if (k <= mbt_pkg::RQ_FC4) begin
      nb = $urandom_range(0, 9);
      if (noisy && $urandom_range(4) == 0) begin
        send_header(t, 16'($urandom_range(0, 14)));
      end else begin
        send_header(t, 16'(3 + nb));
      end
      send_body(8'($urandom));
      send_body(code);
      send_body(8'(noisy && $urandom_range(3) == 0 ? $urandom_range(0, 12) : nb));
      for (int i = 0; i < nb; i++) send_body(8'($urandom));
    end else begin
      send_header(t, 16'(noisy && $urandom_range(3) == 0 ? $urandom_range(2, 7) : 6));
      send_body(8'($urandom));
      send_body(code);
      if ($urandom_range(3) == 0) a = 16'($urandom);
      send_body(a[15:8]); send_body(a[7:0]);
      if (k == mbt_pkg::RQ_FC5) op = op[0] ? mbt_pkg::COIL_ON : mbt_pkg::COIL_OFF;
      if ($urandom_range(3) == 0) op = 16'($urandom);
      send_body(op[15:8]); send_body(op[7:0]);
    end
    finish_frame();
  endtask

  // request then its response
  task automatic transaction(bit noisy);
    logic [2:0]  k;
    logic [15:0] a;
    logic [15:0] op;
    logic [15:0] t;
    k = 3'($urandom_range(0, 6));
    a = 16'($urandom);
    op = (k <= mbt_pkg::RQ_FC4 && $urandom_range(3) != 0) ? 16'($urandom_range(0, 40))
                                                          : 16'($urandom);
    t = sb.next_tid;
    send_req(k, a, op);
    if (noisy && $urandom_range(5) == 0) t = 16'($urandom);
    send_frame(t, k, a, op, noisy);
  endtask

  initial begin
    int phase;
    sb = new();
    rst = 1; item_valid = 0; item = '0;
    hold_off = 0; send_idle_pct = 0; stall_pct = 0; items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: bad kind, several kinds, full table, special frames
    send_req(mbt_pkg::RQ_BAD, 16'hFFFF, 16'hFFFF);
    send_req(mbt_pkg::RQ_FC2, 16'hFFFE, 16'd20);
    send_frame(16'd1, mbt_pkg::RQ_FC2, 16'hFFFE, 16'd20, 0);
    send_req(mbt_pkg::RQ_FC3, 16'hFFFF, 16'hFFFF);
    send_frame(16'd2, mbt_pkg::RQ_FC3, 16'd0, 16'd0, 0);
    send_header(16'h0000, 16'd0);
    send_header(16'hFFFF, 16'd1);
    send_byte(8'hFF);
    send_header(16'hABCD, 16'd2);
    send_byte(8'h00); send_byte(8'h00);
    for (int i = 0; i < DEPTH + 1; i++)
      send_req(3'(mbt_pkg::RQ_FC5 + (i % 3)), 16'(i), 16'h0001);
    drain();

    // flush the table with matching frames
    for (int s = 0; s < DEPTH; s++)
      if (sb.slot_used[s]) send_frame(sb.slot_tid[s], sb.slot_kind[s], sb.slot_addr[s],
                                      sb.slot_op[s], 0);
    drain();

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++)
        send_req(3'($urandom_range(0, 6)), 16'($urandom), 16'($urandom));
    join
    drain();

    // random part over idle and stall phases
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin send_idle_pct = 74; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 74; end
        3: begin send_idle_pct = 17; stall_pct = 17; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      while (items_sent < 180 * (phase + 1)) begin
        case ($urandom_range(9))
          0: send_req(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
          1: send_body(8'($urandom));
          default: transaction($urandom_range(2) == 0);
        endcase
        finish_frame();
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_ctrl.sv
hw/rtl/mbt_datapath.sv
hw/rtl/modbus_tcp_response_tracker.sv
verif/modbus_tcp_response_tracker_test.sv
